// ===== rtl/upd_pkg.sv =====
// Shared types, character constants and hex helpers for the URL percent decoder.
package upd_pkg;

  localparam logic [7:0] CH_PERCENT = 8'h25;
  localparam logic [7:0] CH_PLUS    = 8'h2B;
  localparam logic [7:0] CH_SPACE   = 8'h20;

  localparam logic KIND_CHAR = 1'b0;
  localparam logic KIND_END  = 1'b1;

  localparam int QUEUE_DEPTH_DEF = 4;

  // One decoded burst: cnt results (1..3), the last one the end marker
  // when with_end is set.
  typedef struct packed {
    logic [1:0] cnt;
    logic       with_end;
    logic [7:0] b0;
    logic [7:0] b1;
    logic [7:0] b2;
  } cmd_t;

  function automatic logic is_hex(input logic [7:0] c);
    is_hex = (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h46) ||
             (c >= 8'h61 && c <= 8'h66);
  endfunction

  function automatic logic [3:0] hex_val(input logic [7:0] c);
    logic [7:0] d;
    d = 8'h00;
    if (c >= 8'h30 && c <= 8'h39) begin
      d = c - 8'h30;
    end else if (c >= 8'h41 && c <= 8'h46) begin
      d = c - 8'h37;
    end else if (c >= 8'h61 && c <= 8'h66) begin
      d = c - 8'h57;
    end
    hex_val = d[3:0];
  endfunction

endpackage

// ===== rtl/upd_front.sv =====
// Front end: accepts characters, tracks escape state, builds result bursts.
module upd_front (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_tvalid,
  output logic          in_tready,
  input  logic          in_kind,
  input  logic [7:0]    in_char,
  input  logic          cfg_we,
  input  logic          cfg_wdata,
  input  logic          q_full,
  output logic          q_push,
  output upd_pkg::cmd_t q_cmd
);
  import upd_pkg::*;

  typedef enum logic [2:0] {
    PH_IDLE = 3'b001,
    PH_PCT  = 3'b010,
    PH_HELD = 3'b100
  } phase_t;

  phase_t     phase_r, phase_nxt;
  logic [7:0] held_r, held_nxt;
  logic       plus_r;
  logic       accept;
  cmd_t       cmd;

  assign in_tready = !q_full;
  assign accept    = in_tvalid && in_tready;

  always_comb begin
    cmd.cnt      = 2'd0;
    cmd.with_end = 1'b0;
    cmd.b0       = in_char;
    cmd.b1       = 8'h00;
    cmd.b2       = 8'h00;
    phase_nxt    = phase_r;
    held_nxt     = held_r;
    if (in_kind == KIND_END) begin
      // flush pending escape characters ahead of the end marker
      cmd.with_end = 1'b1;
      phase_nxt    = PH_IDLE;
      if (phase_r == PH_PCT) begin
        cmd.cnt = 2'd2;
        cmd.b0  = CH_PERCENT;
      end else if (phase_r == PH_HELD) begin
        cmd.cnt = 2'd3;
        cmd.b0  = CH_PERCENT;
        cmd.b1  = held_r;
      end else begin
        cmd.cnt = 2'd1;
        cmd.b0  = 8'h00;
      end
    end else if (phase_r == PH_PCT) begin
      held_nxt  = in_char;
      phase_nxt = PH_HELD;
    end else if (phase_r == PH_HELD) begin
      phase_nxt = PH_IDLE;
      if (is_hex(held_r) && is_hex(in_char)) begin
        cmd.cnt = 2'd1;
        cmd.b0  = {hex_val(held_r), hex_val(in_char)};
      end else begin
        cmd.cnt = 2'd3;
        cmd.b0  = CH_PERCENT;
        cmd.b1  = held_r;
        cmd.b2  = in_char;
      end
    end else begin
      phase_nxt = PH_IDLE;
      if (in_char == CH_PERCENT) begin
        phase_nxt = PH_PCT;
      end else begin
        cmd.cnt = 2'd1;
        if (plus_r && in_char == CH_PLUS) begin
          cmd.b0 = CH_SPACE;
        end
      end
    end
  end

  assign q_cmd  = cmd;
  assign q_push = accept && (cmd.cnt != 2'd0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      held_r  <= 8'h00;
      plus_r  <= 1'b0;
    end else begin
      if (accept) begin
        phase_r <= phase_nxt;
        held_r  <= held_nxt;
      end
      if (cfg_we) begin
        plus_r <= cfg_wdata;
      end
    end
  end

endmodule

// ===== rtl/upd_queue.sv =====
// Small register queue of result bursts between front and back end.
module upd_queue #(
  parameter int DEPTH = upd_pkg::QUEUE_DEPTH_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  upd_pkg::cmd_t push_cmd,
  output logic          full,
  input  logic          pop,
  output logic          head_valid,
  output upd_pkg::cmd_t head_cmd
);
  import upd_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  cmd_t          mem_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, rd_ptr_r;
  logic [CW-1:0] count_r;

  assign full       = (count_r == CW'(DEPTH));
  assign head_valid = (count_r != '0);
  assign head_cmd   = mem_r[rd_ptr_r];

  function automatic logic [PW-1:0] wrap_inc(input logic [PW-1:0] p);
    wrap_inc = (p == PW'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wrap_inc(wr_ptr_r);
      end
      if (pop) begin
        rd_ptr_r <= wrap_inc(rd_ptr_r);
      end
      if (push && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (pop && !push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !full) else $error("queue written while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> head_valid) else $error("queue read while empty");
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(DEPTH)) else $error("queue count beyond depth");

endmodule

// ===== rtl/upd_back.sv =====
// Back end: steps through each burst and drives one result per cycle unless the output stalls.
module upd_back (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          q_valid,
  input  upd_pkg::cmd_t q_cmd,
  output logic          q_pop,
  output logic          out_tvalid,
  input  logic          out_tready,
  output logic [7:0]    out_byte,
  output logic          out_has_byte,
  output logic          out_last,
  output logic          out_stream_end
);
  import upd_pkg::*;

  cmd_t       cur_r;
  logic       cur_valid_r;
  logic [1:0] idx_r;
  logic       out_valid_r;
  logic [7:0] byte_r;
  logic       has_r, last_r, end_r;
  logic       slot_free, emit, is_last, is_endm;
  logic [7:0] sel_byte;

  assign sel_byte  = (idx_r == 2'd0) ? cur_r.b0 : (idx_r == 2'd1) ? cur_r.b1 : cur_r.b2;
  assign is_last   = (idx_r == 2'(cur_r.cnt - 2'd1));
  assign is_endm   = cur_r.with_end && is_last;
  assign slot_free = !out_valid_r || out_tready;
  assign emit      = cur_valid_r && slot_free;
  assign q_pop     = q_valid && (!cur_valid_r || (emit && is_last));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_valid_r <= 1'b0;
      idx_r       <= 2'd0;
      out_valid_r <= 1'b0;
    end else begin
      if (q_pop) begin
        cur_valid_r <= 1'b1;
        idx_r       <= 2'd0;
      end else if (emit && is_last) begin
        cur_valid_r <= 1'b0;
      end else if (emit) begin
        idx_r <= idx_r + 2'd1;
      end
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur_r <= q_cmd;
    end
    if (emit) begin
      byte_r <= is_endm ? 8'h00 : sel_byte;
      has_r  <= !is_endm;
      last_r <= is_last;
      end_r  <= is_endm;
    end
  end

  assign out_tvalid     = out_valid_r;
  assign out_byte       = byte_r;
  assign out_has_byte   = has_r;
  assign out_last       = last_r;
  assign out_stream_end = end_r;

  a_end_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && end_r |-> last_r && !has_r)
    else $error("end marker not last or carries a byte");
  a_cur_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    cur_valid_r |-> cur_r.cnt != 2'd0) else $error("empty burst in back end");
  a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
    cur_valid_r |-> idx_r < cur_r.cnt) else $error("result index past burst");

endmodule

// ===== rtl/url_percent_decoder_top.sv =====
// Top level of the streaming URL percent decoder.
//
// Decodes a byte stream one character per item: "%hh" (either case)
// becomes one byte, a malformed escape is passed on as '%' plus both
// characters without rescanning them, and with plus_as_space set a '+'
// outside an escape becomes a space. An end item (in_tuser = 1) flushes
// any pending '%' or '%X' and then delivers a result with
// out_tuser[1] (stream end) set and out_tuser[0] (byte valid) clear.
// out_tlast marks the final result caused by each input item; items that
// only open an escape cause no result. Rate: one input item per cycle
// while the queue has room, one result per cycle while out_tready is
// high. A front end classifies items and pushes each burst of one to
// three results into a QUEUE_DEPTH-entry queue; the back end drains a
// burst one result at a time, and the input stalls only when the queue
// fills. A result passes a queue entry, the burst register and the
// output register. plus_as_space is written through cfg_we / cfg_wdata,
// which should only be used while the block is idle; it resets to 0.
module url_percent_decoder_top #(
  parameter int QUEUE_DEPTH = upd_pkg::QUEUE_DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  // input items
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] char_in
  input  logic       in_tuser,   // [0] kind (0 character, 1 end of string)
  // result items
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,  // [7:0] out_byte
  output logic       out_tlast,  // last result of the input item
  output logic [1:0] out_tuser,  // [0] has_byte, [1] stream_end
  // configuration
  input  logic       cfg_we,
  input  logic       cfg_wdata   // plus_as_space
);
  import upd_pkg::*;

  logic q_full, q_push, q_pop, q_valid;
  cmd_t push_cmd, head_cmd;
  logic has_byte, stream_end;

  // Front: hold escape state, classify each item into a result burst.
  upd_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_kind   (in_tuser),
    .in_char   (in_tdata),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_cmd     (push_cmd)
  );

  // Queue: decouple the front from output backpressure.
  upd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_cmd   (push_cmd),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_valid),
    .head_cmd   (head_cmd)
  );

  // Back: advance through each burst, one registered result per cycle unless stalled.
  upd_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_valid        (q_valid),
    .q_cmd          (head_cmd),
    .q_pop          (q_pop),
    .out_tvalid     (out_tvalid),
    .out_tready     (out_tready),
    .out_byte       (out_tdata),
    .out_has_byte   (has_byte),
    .out_last       (out_tlast),
    .out_stream_end (stream_end)
  );

  assign out_tuser = {stream_end, has_byte};

endmodule

// ===== sim/url_percent_decoder_top_test.sv =====
`timescale 1ns / 100ps
// Self-checking stream testbench for the URL percent decoder top level.
module url_percent_decoder_top_test;
  import upd_pkg::*;

  localparam int CYCLE_LIMIT     = 200000;
  localparam int SETTLE_CYCLES   = 6;     // pipeline settle margin
  localparam int RAND_PHASES     = 4;
  localparam int ITEMS_PER_PHASE = 32;

  // escape tracking of the decode mirror
  localparam logic [1:0] ESC_IDLE = 2'd0;  // no escape open
  localparam logic [1:0] ESC_PCT  = 2'd1;  // '%' seen
  localparam logic [1:0] ESC_HELD = 2'd2;  // '%' and one character seen

  typedef struct packed {
    logic [7:0] data;
    logic       has_byte;
    logic       is_last;
    logic       stream_end;
  } result_t;

  typedef struct packed {
    logic       kind;
    logic [7:0] ch;
  } item_t;

  typedef enum logic [1:0] {ROW_CHAR, ROW_END, ROW_CFG} row_op_t;

  // One line of the directed script: a character, an end item or a
  // register write; typed rows carry their single expected result.
  typedef struct packed {
    row_op_t    op;
    logic [7:0] ch;
    logic       typed;
    result_t    want;
  } row_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_tvalid = 1'b0;
  logic       in_tready;
  logic [7:0] in_tdata = 8'h00;  // [7:0] char_in
  logic       in_tuser = 1'b0;   // [0] kind
  logic       out_tvalid;
  logic       out_tready = 1'b0;
  logic [7:0] out_tdata;         // [7:0] out_byte
  logic       out_tlast;
  logic [1:0] out_tuser;         // [0] has_byte, [1] stream_end
  logic       cfg_we = 1'b0;
  logic       cfg_wdata = 1'b0;

  // Decode mirror state and the bytes it still waits for.
  logic       plus_mode = 1'b0;
  logic [1:0] esc_phase = ESC_IDLE;
  logic [7:0] esc_char = 8'h00;
  result_t    decoded_q[$];
  item_t      token_q[$];

  logic       calm = 1'b0;       // set to run a stretch without any idling
  int         err_cnt = 0;
  int         cycle_cnt = 0;

  url_percent_decoder_top i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Abort a hung run.
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("url_percent_decoder_top: mismatch");
      $finish;
    end
  end

  // Return {valid, value} of a hex digit; valid is clear for anything else.
  function automatic logic [4:0] nibble_of(input logic [7:0] c);
    if (c >= "0" && c <= "9") return {1'b1, c[3:0]};
    if ((c >= "A" && c <= "F") || (c >= "a" && c <= "f")) return {1'b1, c[3:0] + 4'd9};
    return 5'b0_0000;
  endfunction

  // Advance the decode mirror by one accepted item, queue the results it
  // causes and return how many were queued.
  function automatic int decode_step(input logic kind, input logic [7:0] c);
    logic [7:0] burst [3];
    logic [4:0] hi;
    logic [4:0] lo;
    logic       with_end;
    int         n;
    n = 0;
    with_end = 1'b0;
    hi = nibble_of(esc_char);
    lo = nibble_of(c);
    if (kind == KIND_END) begin
      // flush an open escape, then close the string
      if (esc_phase != ESC_IDLE) begin
        burst[n] = CH_PERCENT;
        n++;
      end
      if (esc_phase == ESC_HELD) begin
        burst[n] = esc_char;
        n++;
      end
      with_end = 1'b1;
      esc_phase = ESC_IDLE;
    end else if (esc_phase == ESC_IDLE) begin
      if (c == CH_PERCENT) begin
        esc_phase = ESC_PCT;
      end else if (plus_mode && c == CH_PLUS) begin
        burst[n] = CH_SPACE;
        n++;
      end else begin
        burst[n] = c;
        n++;
      end
    end else if (esc_phase == ESC_PCT) begin
      esc_char = c;
      esc_phase = ESC_HELD;
    end else begin
      if (hi[4] && lo[4]) begin
        burst[n] = {hi[3:0], lo[3:0]};
        n++;
      end else begin
        // malformed escape: pass all three characters on untouched
        burst[0] = CH_PERCENT;
        burst[1] = esc_char;
        burst[2] = c;
        n = 3;
      end
      esc_phase = ESC_IDLE;
    end
    for (int i = 0; i < n; i++)
      decoded_q.push_back({burst[i], 1'b1, (i == n - 1) && !with_end, 1'b0});
    if (with_end) begin
      decoded_q.push_back({8'h00, 1'b0, 1'b1, 1'b1});
      n++;
    end
    return n;
  endfunction

  // Mostly short gaps, now and then a long one; none while calm.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 55) return 0;
    if (r < 85) return $urandom_range(1, 2);
    if (r < 97) return $urandom_range(3, 6);
    return $urandom_range(10, 30);
  endfunction

  function automatic logic [7:0] rand_hex();
    int k;
    k = $urandom_range(0, 21);
    if (k < 10) return 8'("0" + k);
    if (k < 16) return 8'("A" + k - 10);
    return 8'("a" + k - 16);
  endfunction

  // Characters that like to sit inside a broken escape.
  function automatic logic [7:0] odd_char();
    int k;
    k = $urandom_range(0, 3);
    if (k == 0) return CH_PERCENT;
    if (k == 1) return CH_PLUS;
    if (k == 2) return rand_hex();
    return 8'($urandom);
  endfunction

  // Fill token_q with one random token: a plain character, a good escape,
  // a broken escape, an end item, or an escape cut short by an end item.
  function automatic void make_token();
    int         pick;
    logic [7:0] a;
    logic [7:0] b;
    logic [4:0] na;
    logic [4:0] nb;
    pick = $urandom_range(0, 99);
    token_q.delete();
    if (pick < 35) begin
      a = ($urandom_range(0, 4) == 0) ? CH_PLUS : 8'($urandom);
      token_q.push_back({KIND_CHAR, a});
    end else if (pick < 65) begin
      token_q.push_back({KIND_CHAR, CH_PERCENT});
      token_q.push_back({KIND_CHAR, rand_hex()});
      token_q.push_back({KIND_CHAR, rand_hex()});
    end else if (pick < 80) begin
      a = odd_char();
      b = odd_char();
      na = nibble_of(a);
      nb = nibble_of(b);
      // force the escape to break: 'g' and up are never hex digits
      if (na[4] && nb[4]) b = 8'($urandom_range(8'h67, 8'hFF));
      token_q.push_back({KIND_CHAR, CH_PERCENT});
      token_q.push_back({KIND_CHAR, a});
      token_q.push_back({KIND_CHAR, b});
    end else if (pick < 88) begin
      token_q.push_back({KIND_END, 8'($urandom)});
    end else begin
      token_q.push_back({KIND_CHAR, CH_PERCENT});
      if ($urandom_range(0, 1) == 1) token_q.push_back({KIND_CHAR, odd_char()});
      token_q.push_back({KIND_END, 8'($urandom)});
    end
  endfunction

  function automatic row_t step_row(input row_op_t op, input logic [7:0] ch,
                                    input logic typed, input logic [7:0] b,
                                    input logic has, input logic fin);
    return {op, ch, typed, b, has, 1'b1, fin};
  endfunction

  // Offer one item after a random gap and hold it until accepted; then
  // predict its results, or queue the typed result in their place.
  task automatic send_item(input logic kind, input logic [7:0] ch,
                           input logic typed, input result_t want);
    int gap;
    int n;
    gap = pick_gap();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= ch;
    in_tuser  <= kind;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    n = decode_step(kind, ch);
    if (typed) begin
      repeat (n) void'(decoded_q.pop_back());
      decoded_q.push_back(want);
    end
  endtask

  // Hold the input until every awaited byte has come, then let an escape
  // that caused no result settle inside the block.
  task automatic wait_drained();
    in_tvalid <= 1'b0;
    while (decoded_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_cfg(input logic plus_as_space);
    wait_drained();
    cfg_we    <= 1'b1;
    cfg_wdata <= plus_as_space;
    @(posedge clk);
    plus_mode = plus_as_space;
    cfg_we    <= 1'b0;
  endtask

  task automatic flag_mismatch(input string what, input result_t want, input result_t got);
    err_cnt++;
    if (err_cnt <= 10)
      $display("%0t %s: want byte=%02h has=%b last=%b end=%b, got byte=%02h has=%b last=%b end=%b",
               $time, what, want.data, want.has_byte, want.is_last, want.stream_end,
               got.data, got.has_byte, got.is_last, got.stream_end);
  endtask

  // Stall the result side at random; the calm stretch never stalls.
  initial begin : result_sink
    int stall_left;
    stall_left = 0;
    forever begin
      @(posedge clk);
      if (stall_left > 0) begin
        out_tready <= 1'b0;
        stall_left--;
      end else begin
        out_tready <= 1'b1;
        if (!calm && $urandom_range(0, 3) == 0) stall_left = pick_gap();
      end
    end
  end

  // Compare every accepted result with the oldest awaited one.
  always @(posedge clk) begin : result_check
    result_t got;
    result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got = {out_tdata, out_tuser[0], out_tlast, out_tuser[1]};
      if (decoded_q.size() == 0) begin
        flag_mismatch("unexpected result", '0, got);
      end else begin
        want = decoded_q.pop_front();
        if (got.data !== want.data || got.has_byte !== want.has_byte ||
            got.is_last !== want.is_last || got.stream_end !== want.stream_end)
          flag_mismatch("wrong result", want, got);
      end
    end
  end

  initial begin : stimulus
    row_t  script[$];
    row_t  r;
    item_t t;
    int    count;

    // Plain bytes at the extremes, '+' left alone, a bare end item.
    script.push_back(step_row(ROW_CHAR, 8'h00, 1'b1, 8'h00, 1'b1, 1'b0));
    script.push_back(step_row(ROW_CHAR, 8'hFF, 1'b1, 8'hFF, 1'b1, 1'b0));
    script.push_back(step_row(ROW_CHAR, CH_PLUS, 1'b1, CH_PLUS, 1'b1, 1'b0));
    script.push_back(step_row(ROW_END, 8'h5A, 1'b1, 8'h00, 1'b0, 1'b1));
    // Form encoding on: '+' turns into a space, but not inside an escape.
    script.push_back(step_row(ROW_CFG, 8'h01, 1'b0, 8'h00, 1'b0, 1'b0));
    script.push_back(step_row(ROW_CHAR, CH_PLUS, 1'b1, CH_SPACE, 1'b1, 1'b0));
    script.push_back(step_row(ROW_CHAR, CH_PERCENT, 1'b0, 8'h00, 1'b0, 1'b0));
    script.push_back(step_row(ROW_CHAR, CH_PLUS, 1'b0, 8'h00, 1'b0, 1'b0));
    script.push_back(step_row(ROW_CHAR, "2", 1'b0, 8'h00, 1'b0, 1'b0));
    // Good escapes in both cases and at the digit boundaries.
    script.push_back(step_row(ROW_CHAR, CH_PERCENT, 1'b0, 8'h00, 1'b0, 1'b0));
    script.push_back(step_row(ROW_CHAR, "4", 1'b0, 8'h00, 1'b0, 1'b0));
    script.push_back(step_row(ROW_CHAR, "1", 1'b0, 8'h00, 1'b0, 1'b0));
    script.push_back(step_row(ROW_CHAR, CH_PERCENT, 1'b0, 8'h00, 1'b0, 1'b0));
    script.push_back(step_row(ROW_CHAR, "f", 1'b0, 8'h00, 1'b0, 1'b0));
    script.push_back(step_row(ROW_CHAR, "F", 1'b0, 8'h00, 1'b0, 1'b0));
    // A '%' inside an escape is not rescanned.
    script.push_back(step_row(ROW_CHAR, CH_PERCENT, 1'b0, 8'h00, 1'b0, 1'b0));
    script.push_back(step_row(ROW_CHAR, CH_PERCENT, 1'b0, 8'h00, 1'b0, 1'b0));
    script.push_back(step_row(ROW_CHAR, "4", 1'b0, 8'h00, 1'b0, 1'b0));
    // End right after '%', then right after '%X', then one more good escape.
    script.push_back(step_row(ROW_CHAR, CH_PERCENT, 1'b0, 8'h00, 1'b0, 1'b0));
    script.push_back(step_row(ROW_END, 8'hC3, 1'b0, 8'h00, 1'b0, 1'b0));
    script.push_back(step_row(ROW_CHAR, CH_PERCENT, 1'b0, 8'h00, 1'b0, 1'b0));
    script.push_back(step_row(ROW_CHAR, "a", 1'b0, 8'h00, 1'b0, 1'b0));
    script.push_back(step_row(ROW_END, 8'h00, 1'b0, 8'h00, 1'b0, 1'b0));
    script.push_back(step_row(ROW_CHAR, CH_PERCENT, 1'b0, 8'h00, 1'b0, 1'b0));
    script.push_back(step_row(ROW_CHAR, "9", 1'b0, 8'h00, 1'b0, 1'b0));
    script.push_back(step_row(ROW_CHAR, "0", 1'b0, 8'h00, 1'b0, 1'b0));

    // Hold reset, then release it for good.
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Walk the directed script.
    foreach (script[i]) begin
      r = script[i];
      if (r.op == ROW_CFG)
        write_cfg(r.ch[0]);
      else
        send_item((r.op == ROW_END) ? KIND_END : KIND_CHAR, r.ch, r.typed, r.want);
    end

    // Random phases, alternating the form-encoding setting; one phase
    // runs without idling on either side. Close each phase with an end
    // item so that the setting changes on a clean string boundary.
    for (int p = 0; p < RAND_PHASES; p++) begin
      write_cfg(!p[0]);
      calm = (p == 2);
      count = 0;
      while (count < ITEMS_PER_PHASE) begin
        make_token();
        count += token_q.size();
        foreach (token_q[k]) begin
          t = token_q[k];
          send_item(t.kind, t.ch, 1'b0, '0);
        end
        // now and then hold the input until the output runs dry
        if ($urandom_range(0, 29) == 0) wait_drained();
      end
      send_item(KIND_END, 8'($urandom), 1'b0, '0);
    end

    // Drain, let the block settle, and give the verdict.
    calm = 1'b0;
    wait_drained();
    if (err_cnt == 0 && decoded_q.size() == 0) begin
      $display("url_percent_decoder_top: match");
    end else begin
      $display("url_percent_decoder_top: mismatch");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/upd_pkg.sv
rtl/upd_front.sv
rtl/upd_queue.sv
rtl/upd_back.sv
rtl/url_percent_decoder_top.sv
sim/url_percent_decoder_top_test.sv
